>>> design/dgn_pkg.sv
// ----------------------------------------------------------------------------
// dgn_pkg
// Shared types and constants for the depth to greyscale normalizer.
// ----------------------------------------------------------------------------
package dgn_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int DATA_W = 32;
	localparam int GREY_W = 8;
	localparam int STEP_W = $clog2(GREY_W);

	localparam logic signed [DATA_W-1:0] DEPTH_MIN_RST = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] DEPTH_MAX_RST = 32'sh8000_0000;

	typedef struct packed {
		logic accept;
		logic rd;
		logic diff;
		logic scale;
		logic div_step;
		logic push;
	} dgn_cmd_t;

	typedef struct packed {
		logic is_last;
		logic out_free;
	} dgn_stat_t;

endpackage

>>> design/depth_to_greyscale_normalizer.sv
// ----------------------------------------------------------------------------
// depth_to_greyscale_normalizer
// Loads a set of points while tracking the depth extremes, then emits each
// stored point with its depth mapped to an 8-bit grey level.
// ----------------------------------------------------------------------------
// Loading accepts one point per cycle, and the point marked final ends the set.
// Each result then passes through store read, span, scaling, a restoring
// divider and the output register write, which waits until the output
// register is free; new points are taken only once the last result is pushed.
// Reset clears the point count, depth extremes, overflow flag and all
// handshake state; the point store itself is not cleared.
// ----------------------------------------------------------------------------
module depth_to_greyscale_normalizer #(
	parameter int MAX_POINTS = dgn_pkg::MAX_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [dgn_pkg::DATA_W-1:0]   pos_x,
	input  logic signed [dgn_pkg::DATA_W-1:0]   pos_y,
	input  logic signed [dgn_pkg::DATA_W-1:0]   depth,
	input  logic                                final_point,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [dgn_pkg::DATA_W-1:0]   out_x,
	output logic signed [dgn_pkg::DATA_W-1:0]   out_y,
	output logic [dgn_pkg::GREY_W-1:0]          grey,
	output logic                                overflowed,
	output logic                                run_end
);

	dgn_pkg::dgn_cmd_t   cmd;
	dgn_pkg::dgn_stat_t  stat;

	dgn_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.final_point (final_point),
		.in_ready    (in_ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	dgn_dpath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.depth      (depth),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_x      (out_x),
		.out_y      (out_y),
		.grey       (grey),
		.overflowed (overflowed),
		.run_end    (run_end)
	);

	a_last_push_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push && stat.is_last |=> in_ready)
		else $error("Input side did not reopen after the last word of a run.");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> stat.out_free)
		else $error("Output register overwritten while holding a word.");

	a_valid_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.push))
		else $error("Output valid rose without a push.");

	a_no_load_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !in_ready)
		else $error("Input accepted while results were being produced.");

endmodule

>>> design/dgn_ctrl.sv
// ----------------------------------------------------------------------------
// dgn_ctrl
// Controller state machine: loads points, then steps the datapath through
// read, span, scale, division and output for each stored point.
// ----------------------------------------------------------------------------
module dgn_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                final_point,
	output logic                in_ready,
	input  dgn_pkg::dgn_stat_t  stat,
	output dgn_pkg::dgn_cmd_t   cmd
);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_DIFF  = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_PUSH  = 3'd5;

	localparam logic [dgn_pkg::STEP_W-1:0] STEP_LAST = dgn_pkg::STEP_W'(dgn_pkg::GREY_W - 1);

	logic [2:0]                  state_q;
	logic [2:0]                  state_d;
	logic [dgn_pkg::STEP_W-1:0]  step_q;

	assign in_ready = (state_q == ST_LOAD);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				cmd.accept = in_valid;
				if (in_valid && final_point) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd = 1'b1;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_LAST) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					state_d = stat.is_last ? ST_LOAD : ST_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step) begin
				step_q <= (step_q == STEP_LAST) ? '0 : step_q + 1'b1;
			end
		end
	end

endmodule

>>> design/dgn_dpath.sv
// ----------------------------------------------------------------------------
// dgn_dpath
// Datapath: point store, depth extremes, scaling, restoring divider and the
// output register.
// ----------------------------------------------------------------------------
module dgn_dpath #(
	parameter int MAX_POINTS = dgn_pkg::MAX_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dgn_pkg::dgn_cmd_t                   cmd,
	output dgn_pkg::dgn_stat_t                  stat,
	input  logic signed [dgn_pkg::DATA_W-1:0]   pos_x,
	input  logic signed [dgn_pkg::DATA_W-1:0]   pos_y,
	input  logic signed [dgn_pkg::DATA_W-1:0]   depth,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [dgn_pkg::DATA_W-1:0]   out_x,
	output logic signed [dgn_pkg::DATA_W-1:0]   out_y,
	output logic [dgn_pkg::GREY_W-1:0]          grey,
	output logic                                overflowed,
	output logic                                run_end
);

	localparam int DW = dgn_pkg::DATA_W;
	localparam int GW = dgn_pkg::GREY_W;
	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int EW = 3 * DW;
	localparam int NW = DW + 1 + GW;

	logic [EW-1:0]           mem [MAX_POINTS];
	logic [EW-1:0]           rd_data_q;
	logic [CW-1:0]           count_q;
	logic [IW-1:0]           rd_idx_q;
	logic signed [DW-1:0]    min_q;
	logic signed [DW-1:0]    max_q;
	logic                    ovf_q;
	logic                    is_last_q;
	logic [DW:0]             d_q;
	logic [DW:0]             span_q;
	logic                    zero_span_q;
	logic [DW:0]             rem_q;
	logic [GW-1:0]           sh_q;
	logic                    out_valid_q;

	logic                    full;
	logic                    store_en;
	logic                    run_done;
	logic [NW-1:0]           num;
	logic [DW+1:0]           trial;
	logic [DW:0]             trial_sub;
	logic                    fits;

	assign full = (count_q == CW'(MAX_POINTS));
	assign store_en = cmd.accept && !full;
	assign run_done = cmd.push && is_last_q;

	assign num = {d_q, {GW{1'b0}}} - {{GW{1'b0}}, d_q};
	assign trial = {rem_q, sh_q[GW-1]};
	assign trial_sub = trial[DW:0] - span_q;
	assign fits = (trial >= {1'b0, span_q});

	assign stat.is_last = is_last_q;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (store_en) begin
			mem[count_q[IW-1:0]] <= {pos_y, pos_x, depth};
		end
		if (cmd.rd) begin
			rd_data_q <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_idx_q <= '0;
			min_q <= dgn_pkg::DEPTH_MIN_RST;
			max_q <= dgn_pkg::DEPTH_MAX_RST;
			ovf_q <= 1'b0;
			is_last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (store_en) begin
				count_q <= count_q + 1'b1;
				if (depth < min_q) begin
					min_q <= depth;
				end
				if (depth > max_q) begin
					max_q <= depth;
				end
			end
			if (cmd.accept && full) begin
				ovf_q <= 1'b1;
			end
			if (cmd.rd) begin
				is_last_q <= ((CW'(rd_idx_q) + CW'(1)) == count_q);
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (run_done) begin
				count_q <= '0;
				rd_idx_q <= '0;
				min_q <= dgn_pkg::DEPTH_MIN_RST;
				max_q <= dgn_pkg::DEPTH_MAX_RST;
				ovf_q <= 1'b0;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			d_q <= {rd_data_q[DW-1], rd_data_q[DW-1:0]} - {min_q[DW-1], min_q};
			span_q <= {max_q[DW-1], max_q} - {min_q[DW-1], min_q};
			zero_span_q <= (max_q == min_q);
		end
		if (cmd.scale) begin
			rem_q <= num[NW-1:GW];
			sh_q <= num[GW-1:0];
		end else if (cmd.div_step) begin
			rem_q <= fits ? trial_sub : trial[DW:0];
			sh_q <= {sh_q[GW-2:0], fits};
		end
		if (cmd.push) begin
			out_x <= rd_data_q[2*DW-1:DW];
			out_y <= rd_data_q[3*DW-1:2*DW];
			grey <= zero_span_q ? '0 : sh_q;
			overflowed <= ovf_q;
			run_end <= is_last_q;
		end
	end

endmodule

>>> test/depth_to_greyscale_normalizer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_to_greyscale_normalizer_checker
// Watches the point and result channels of the normalizer and keeps its own
// copy of the point store and depth extremes. Every accepted final point
// queues the grey words due for the set, and every accepted result word is
// checked field by field against the oldest of them.
// ----------------------------------------------------------------------------
module depth_to_greyscale_normalizer_checker #(
	parameter int MAX_POINTS = dgn_pkg::MAX_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic signed [dgn_pkg::DATA_W-1:0]   pos_x,
	input  logic signed [dgn_pkg::DATA_W-1:0]   pos_y,
	input  logic signed [dgn_pkg::DATA_W-1:0]   depth,
	input  logic                                final_point,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [dgn_pkg::DATA_W-1:0]   out_x,
	input  logic signed [dgn_pkg::DATA_W-1:0]   out_y,
	input  logic [dgn_pkg::GREY_W-1:0]          grey,
	input  logic                                overflowed,
	input  logic                                run_end,
	output int                                  fail_count,
	output int                                  results_due
);

	typedef struct {
		logic signed [dgn_pkg::DATA_W-1:0] x;
		logic signed [dgn_pkg::DATA_W-1:0] y;
		logic [dgn_pkg::GREY_W-1:0]        level;
		logic                              ovf;
		logic                              last;
	} grey_word_t;

	logic signed [dgn_pkg::DATA_W-1:0] x_kept [MAX_POINTS];
	logic signed [dgn_pkg::DATA_W-1:0] y_kept [MAX_POINTS];
	logic signed [dgn_pkg::DATA_W-1:0] z_kept [MAX_POINTS];
	int                                points_kept;
	logic signed [dgn_pkg::DATA_W-1:0] z_low;
	logic signed [dgn_pkg::DATA_W-1:0] z_high;
	logic                              points_dropped;
	grey_word_t                        grey_words_due [$];
	int                                fails;

	function automatic void restart_set();
		points_kept = 0;
		z_low = dgn_pkg::DEPTH_MIN_RST;
		z_high = dgn_pkg::DEPTH_MAX_RST;
		points_dropped = 1'b0;
	endfunction

	function automatic void take_point(
		input logic signed [dgn_pkg::DATA_W-1:0] x,
		input logic signed [dgn_pkg::DATA_W-1:0] y,
		input logic signed [dgn_pkg::DATA_W-1:0] z,
		input logic last
	);
		longint span;
		longint offset;
		longint level;
		grey_word_t w;
		if (points_kept < MAX_POINTS) begin
			x_kept[points_kept] = x;
			y_kept[points_kept] = y;
			z_kept[points_kept] = z;
			points_kept++;
			if (z < z_low)
				z_low = z;
			if (z > z_high)
				z_high = z;
		end else begin
			points_dropped = 1'b1;
		end
		if (last) begin
			span = longint'(z_high) - longint'(z_low);
			for (int k = 0; k < points_kept; k++) begin
				offset = longint'(z_kept[k]) - longint'(z_low);
				level = 0;
				if (span > 0 && offset > 0) begin
					level = (offset * 255) / span;
					if (level > 255)
						level = 255;
				end
				w.x = x_kept[k];
				w.y = y_kept[k];
				w.level = level[dgn_pkg::GREY_W-1:0];
				w.ovf = points_dropped;
				w.last = (k == points_kept - 1);
				grey_words_due.insert(grey_words_due.size(), w);
			end
			restart_set();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grey_word_t w;
		if (!arst_n) begin
			restart_set();
			grey_words_due.delete();
			fails = 0;
			fail_count <= 0;
			results_due <= 0;
		end else begin
			if (in_valid && in_ready)
				take_point(pos_x, pos_y, depth, final_point);
			if (out_valid && out_ready) begin
				if (grey_words_due.size() == 0) begin
					$error("unexpected word: out_x %0d out_y %0d grey %0d", out_x, out_y, grey);
					fails++;
				end else begin
					w = grey_words_due.pop_front();
					if (out_x !== w.x) begin
						$error("out_x: expected %0d, got %0d", w.x, out_x);
						fails++;
					end
					if (out_y !== w.y) begin
						$error("out_y: expected %0d, got %0d", w.y, out_y);
						fails++;
					end
					if (grey !== w.level) begin
						$error("grey: expected %0d, got %0d", w.level, grey);
						fails++;
					end
					if (overflowed !== w.ovf) begin
						$error("overflowed: expected %0b, got %0b", w.ovf, overflowed);
						fails++;
					end
					if (run_end !== w.last) begin
						$error("run_end: expected %0b, got %0b", w.last, run_end);
						fails++;
					end
				end
			end
			fail_count <= fails;
			results_due <= grey_words_due.size();
		end
	end

endmodule

>>> test/depth_to_greyscale_normalizer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_to_greyscale_normalizer_test
// Drives point sets into the normalizer: a directed opening with the field
// extremes, equal depths and narrow spans, then random sets, mostly small,
// with one full store and one set that overflows and drops its final point.
// Points arrive in bursts with random gaps while the result side stalls in
// changing patterns; the checker beside the block judges every result word.
// ----------------------------------------------------------------------------
module depth_to_greyscale_normalizer_test;

	localparam int MAX_POINTS = dgn_pkg::MAX_POINTS_DEF;
	localparam int POINT_TARGET = 380;
	localparam logic signed [dgn_pkg::DATA_W-1:0] Q_MOST_NEG = 32'sh8000_0000;
	localparam logic signed [dgn_pkg::DATA_W-1:0] Q_MOST_POS = 32'sh7fff_ffff;

	typedef enum int {
		SPREAD_FULL,
		SPREAD_NARROW,
		SPREAD_EXTREME,
		SPREAD_FLAT
	} depth_spread_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic signed [dgn_pkg::DATA_W-1:0] pos_x = '0;
	logic signed [dgn_pkg::DATA_W-1:0] pos_y = '0;
	logic signed [dgn_pkg::DATA_W-1:0] depth = '0;
	logic                              final_point = 1'b0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic signed [dgn_pkg::DATA_W-1:0] out_x;
	logic signed [dgn_pkg::DATA_W-1:0] out_y;
	logic [dgn_pkg::GREY_W-1:0]        grey;
	logic                              overflowed;
	logic                              run_end;
	int                                fail_count;
	int                                results_due;
	int                                burst_left = 0;
	int                                points_sent = 0;
	int                                stall_left = 0;
	int                                stall_mode = 0;

	depth_to_greyscale_normalizer #(.MAX_POINTS(MAX_POINTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_x(pos_x), .pos_y(pos_y), .depth(depth), .final_point(final_point),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .grey(grey),
		.overflowed(overflowed), .run_end(run_end)
	);

	depth_to_greyscale_normalizer_checker #(.MAX_POINTS(MAX_POINTS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_x(pos_x), .pos_y(pos_y), .depth(depth), .final_point(final_point),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .grey(grey),
		.overflowed(overflowed), .run_end(run_end),
		.fail_count(fail_count), .results_due(results_due)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(8, 120);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 4) == 0);
			default: out_ready <= (stall_left % 8 == 0);
		endcase
	end

	task automatic send_point(
		input logic signed [dgn_pkg::DATA_W-1:0] x,
		input logic signed [dgn_pkg::DATA_W-1:0] y,
		input logic signed [dgn_pkg::DATA_W-1:0] z,
		input logic last
	);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		depth <= z;
		final_point <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		points_sent++;
	endtask

	function automatic logic signed [dgn_pkg::DATA_W-1:0] pick_depth(
		input depth_spread_t spread,
		input logic signed [dgn_pkg::DATA_W-1:0] centre
	);
		case (spread)
			SPREAD_FULL: return $urandom;
			SPREAD_NARROW: return centre + 32'($urandom_range(0, 600)) - 32'sd300;
			SPREAD_EXTREME: begin
				case ($urandom_range(0, 4))
					0: return Q_MOST_NEG;
					1: return Q_MOST_POS;
					2: return '0;
					3: return '1;
					default: return $urandom;
				endcase
			end
			default: return centre;
		endcase
	endfunction

	task automatic send_set(input int size, input depth_spread_t spread);
		logic signed [dgn_pkg::DATA_W-1:0] centre;
		centre = $urandom;
		for (int i = 0; i < size; i++)
			send_point($urandom, $urandom, pick_depth(spread, centre), i == size - 1);
	endtask

	initial begin
		int set_index;
		int size;
		int roll;
		depth_spread_t spread;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_point(Q_MOST_NEG, Q_MOST_POS, '0, 1'b1);

		send_point('0, '1, Q_MOST_NEG, 1'b0);
		send_point(Q_MOST_POS, Q_MOST_NEG, Q_MOST_POS, 1'b0);
		send_point('1, '0, '0, 1'b0);
		send_point(32'sh0001_0000, -32'sh0001_0000, '1, 1'b1);

		send_point(32'sh1234_5678, 32'sh0fed_cba9, 32'sh0001_8000, 1'b0);
		send_point(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0001_8000, 1'b0);
		send_point(32'shaaaa_aaaa, 32'sh5555_5555, 32'sh0001_8000, 1'b1);

		send_point(32'sd1, 32'sd2, -32'sd10, 1'b0);
		send_point(32'sd3, 32'sd4, -32'sd7, 1'b0);
		send_point(32'sd5, 32'sd6, -32'sd3, 1'b0);
		send_point(32'sd7, 32'sd8, -32'sd10, 1'b1);

		send_point(-32'sd100, 32'sd100, 32'sd100, 1'b0);
		send_point(32'sd100, -32'sd100, -32'sd100, 1'b1);

		set_index = 0;
		while (points_sent < POINT_TARGET) begin
			roll = $urandom_range(0, 9);
			if (roll < 4)
				spread = SPREAD_FULL;
			else if (roll < 8)
				spread = SPREAD_NARROW;
			else if (roll == 8)
				spread = SPREAD_EXTREME;
			else
				spread = SPREAD_FLAT;
			if (set_index == 4)
				size = MAX_POINTS;
			else if (set_index == 9)
				size = MAX_POINTS + $urandom_range(1, 3);
			else if ($urandom_range(0, 5) == 0)
				size = $urandom_range(9, 24);
			else
				size = $urandom_range(1, 8);
			send_set(size, spread);
			set_index++;
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
